>>> hw/rtl/sorted_range_trim_buffer_defines.svh
// Assertion macros used by the checker file of the sorted range trim buffer.
// Needs nothing else; every macro expects a clock and a synchronous reset name.
`ifndef SORTED_RANGE_TRIM_BUFFER_DEFINES_SVH
`define SORTED_RANGE_TRIM_BUFFER_DEFINES_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define SRTB_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("srtb check failed in %m");

// Next-cycle implication, checked at each rising edge outside reset.
`define SRTB_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("srtb check failed in %m");

`endif

>>> hw/rtl/srtb_pkg.sv
// Package of the sorted range trim buffer: codes, state and cell control types.
// Used by the cell and the top level; depends on nothing.
package srtb_pkg;

  localparam int KEEP_W    = 5;
  localparam int REG_IDX_W = 2;

  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  localparam logic [REG_IDX_W-1:0] REG_MIN_VALUE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_VALUE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // What every cell does at the next edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_ROTATE,
    CELL_INS,
    CELL_INS_FULL
  } srtb_act_t;

  typedef struct packed {
    srtb_act_t act;
    logic      valid;
    logic      is_top;
  } srtb_cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAN_PRE,
    ST_INSERT,
    ST_CLEAN_POST,
    ST_READ
  } srtb_state_t;

endpackage

>>> hw/rtl/srtb_ifs.sv
// Valid/ready channel interfaces of the sorted range trim buffer.
// The command channel carries op and value, the result channel one entry per beat.
interface srtb_cmd_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, op, value, input ready);
  modport sink (input valid, op, value, output ready);
endinterface

interface srtb_res_if #(parameter int VALUE_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] entry;
  logic                          last;
  logic                          empty_res;

  modport source (output valid, entry, last, empty_res, input ready);
  modport sink (input valid, entry, last, empty_res, output ready);
endinterface

>>> hw/rtl/srtb_cell.sv
// One cell of the sorted chain: holds one entry and takes a neighbor's value on command.
// Depends on srtb_pkg for the cell control struct.
module srtb_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  srtb_pkg::srtb_cell_ctl_t      ctl,
  input  logic signed [VALUE_WIDTH-1:0] lo_data,
  input  logic                          lo_le,
  input  logic signed [VALUE_WIDTH-1:0] hi_data,
  input  logic                          hi_le,
  input  logic signed [VALUE_WIDTH-1:0] first_data,
  input  logic signed [VALUE_WIDTH-1:0] ins_value,
  input  logic signed [VALUE_WIDTH-1:0] max_value,
  output logic signed [VALUE_WIDTH-1:0] data,
  output logic                          le,
  output logic                          top_above
);

  logic signed [VALUE_WIDTH-1:0] data_next;

  // A valid entry not above the new value stays below it in the order.
  assign le        = ctl.valid && (data <= ins_value);
  assign top_above = ctl.is_top && (data > max_value);

  always_comb begin
    case (ctl.act)
      srtb_pkg::CELL_SHIFT:    data_next = hi_data;
      srtb_pkg::CELL_ROTATE:   data_next = ctl.is_top ? first_data : hi_data;
      srtb_pkg::CELL_INS:      data_next = le ? data : (lo_le ? ins_value : lo_data);
      srtb_pkg::CELL_INS_FULL: data_next = hi_le ? hi_data : (le ? ins_value : data);
      default:                 data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

>>> hw/rtl/sorted_range_trim_buffer.sv
// Sorted range trim buffer: block with a command channel, a result channel
// and an APB-style register port. It keeps up to CAPACITY signed fixed-point
// entries in ascending order in a row of cells, smallest in cell 0.
//
// Command beats carry op and value. An insert (op 0) drops its value when it
// lies outside [min_value, max_value], else places it in order and then drops
// the smallest entries beyond keep_count. A read (op 1) sends every entry in
// ascending order, one beat per entry, last set on the final one; an empty
// store sends one beat with entry 0, last 1 and empty_res 1.
// Before each command the store is cleaned with the registers as they stand:
// entries outside the limits go first, then the smallest beyond keep_count.
//
// Sequence: cleaning (the range filter removes up to one entry at each end
// per cycle, the count trim one entry per cycle) runs until nothing is left
// to drop. An insert then places the value, trims one more entry when the
// count then exceeds keep_count, and returns to idle; ready is low from the
// command until then. A read then sends one beat per cycle while the receiver
// takes them, rotating the row once per beat; a stalling receiver holds the
// result register and the rotation, and ready stays low until the last beat
// is loaded. Reset empties the store, limits full.
module sorted_range_trim_buffer #(
  parameter  int CAPACITY    = 16,
  parameter  int VALUE_WIDTH = 32,
  localparam int DATA_W      = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB    = (VALUE_WIDTH > 32) ? 3 : 2,
  localparam int PADDR_W     = ADDR_LSB + srtb_pkg::REG_IDX_W
) (
  input  logic               clk,
  input  logic               rst,
  srtb_cmd_if.sink           cmd,
  srtb_res_if.source         res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LIM_W = (CNT_W > srtb_pkg::KEEP_W) ? CNT_W : srtb_pkg::KEEP_W;

  // Configuration registers.
  logic signed [VALUE_WIDTH-1:0]      min_value;
  logic signed [VALUE_WIDTH-1:0]      max_value;
  logic [srtb_pkg::KEEP_W-1:0]        keep_count;
  logic [srtb_pkg::REG_IDX_W-1:0]     reg_idx;
  logic                               cfg_write;

  // Control state.
  srtb_pkg::srtb_state_t              state;
  srtb_pkg::srtb_state_t              state_next;
  logic [CNT_W-1:0]                   cnt;
  logic [CNT_W-1:0]                   cnt_next;
  logic [IDX_W-1:0]                   rd_idx;
  logic [IDX_W-1:0]                   rd_idx_next;
  srtb_pkg::srtb_act_t                act;

  // Held command.
  logic                               op_hold;
  logic signed [VALUE_WIDTH-1:0]      value_hold;

  // Result register.
  logic                               res_valid;
  logic signed [VALUE_WIDTH-1:0]      res_entry;
  logic                               res_last;
  logic                               res_empty;
  logic                               res_load;
  logic signed [VALUE_WIDTH-1:0]      res_entry_next;
  logic                               res_last_next;
  logic                               res_empty_next;

  // Cell row.
  srtb_pkg::srtb_cell_ctl_t           cell_ctl  [CAPACITY];
  logic signed [VALUE_WIDTH-1:0]      cell_data [CAPACITY];
  logic [CAPACITY-1:0]                cell_le;
  logic [CAPACITY-1:0]                top_above;

  // Cleaning and insert decisions.
  logic [LIM_W-1:0]                   keep_ext;
  logic [CNT_W-1:0]                   lim;
  logic                               drop_low;
  logic                               drop_high;
  logic                               drop_high_eff;
  logic                               clean_step;
  logic [CNT_W-1:0]                   cnt_cleaned;
  logic                               full;
  logic                               value_in_limits;
  logic                               ins_ok;
  logic                               rd_last;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:ADDR_LSB];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value  <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      max_value  <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      keep_count <= srtb_pkg::KEEP_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        srtb_pkg::REG_MIN_VALUE:  min_value  <= pwdata[VALUE_WIDTH-1:0];
        srtb_pkg::REG_MAX_VALUE:  max_value  <= pwdata[VALUE_WIDTH-1:0];
        srtb_pkg::REG_KEEP_COUNT: keep_count <= pwdata[srtb_pkg::KEEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      srtb_pkg::REG_MIN_VALUE:  prdata = DATA_W'(min_value);
      srtb_pkg::REG_MAX_VALUE:  prdata = DATA_W'(max_value);
      srtb_pkg::REG_KEEP_COUNT: prdata = DATA_W'(keep_count);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Cell row: each cell sees its lower and upper neighbor, the head cell
  // for the read rotation, and the held value for inserts.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int LO = (i == 0) ? 0 : i - 1;
    localparam int HI = (i == CAPACITY - 1) ? i : i + 1;

    assign cell_ctl[i] = '{
      act:    act,
      valid:  (CNT_W'(i) < cnt),
      is_top: (cnt != '0) && (CNT_W'(i) == cnt - CNT_W'(1))
    };

    srtb_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .lo_data   (cell_data[LO]),
      .lo_le     ((i == 0) ? 1'b1 : cell_le[LO]),
      .hi_data   (cell_data[HI]),
      .hi_le     ((i == CAPACITY - 1) ? 1'b0 : cell_le[HI]),
      .first_data(cell_data[0]),
      .ins_value (value_hold),
      .max_value (max_value),
      .data      (cell_data[i]),
      .le        (cell_le[i]),
      .top_above (top_above[i])
    );
  end

  // keep_count saturates at the capacity of the row.
  assign keep_ext = LIM_W'(keep_count);
  assign lim      = (keep_ext > LIM_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(keep_ext);

  // The store is sorted, so out-of-limit entries sit at the two ends. The
  // count trim only starts once both ends are inside the limits, which keeps
  // the range filter ahead of the trim.
  assign drop_high     = |top_above;
  assign drop_low      = (cnt != '0) &&
                         ((cell_data[0] < min_value) || ((cnt > lim) && !drop_high));
  // A single entry that fails both limits leaves only once.
  assign drop_high_eff = drop_high && !(drop_low && (cnt == CNT_W'(1)));
  assign clean_step    = drop_low || drop_high;
  assign cnt_cleaned   = cnt - CNT_W'(drop_low) - CNT_W'(drop_high_eff);

  // When the row is full, the smallest of all values leaves; a new value
  // below every stored entry is that smallest one and is dropped.
  assign full            = (cnt == CNT_W'(CAPACITY));
  assign value_in_limits = (value_hold >= min_value) && (value_hold <= max_value);
  assign ins_ok          = value_in_limits && (!full || cell_le[0]);

  assign rd_last = (CNT_W'(rd_idx) == cnt - CNT_W'(1));

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign cmd.ready = (state == srtb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= srtb_pkg::ST_IDLE;
      cnt    <= '0;
      rd_idx <= '0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      rd_idx <= rd_idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    rd_idx_next    = rd_idx;
    act            = srtb_pkg::CELL_HOLD;
    res_load       = 1'b0;
    res_entry_next = cell_data[0];
    res_last_next  = rd_last;
    res_empty_next = 1'b0;

    unique case (state)
      srtb_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = srtb_pkg::ST_CLEAN_PRE;
        end
      end

      srtb_pkg::ST_CLEAN_PRE: begin
        if (clean_step) begin
          act      = drop_low ? srtb_pkg::CELL_SHIFT : srtb_pkg::CELL_HOLD;
          cnt_next = cnt_cleaned;
        end else if (op_hold == srtb_pkg::OP_READ) begin
          state_next = srtb_pkg::ST_READ;
        end else begin
          state_next = srtb_pkg::ST_INSERT;
        end
      end

      srtb_pkg::ST_INSERT: begin
        if (ins_ok) begin
          act      = full ? srtb_pkg::CELL_INS_FULL : srtb_pkg::CELL_INS;
          cnt_next = full ? cnt : cnt + CNT_W'(1);
        end
        state_next = srtb_pkg::ST_CLEAN_POST;
      end

      srtb_pkg::ST_CLEAN_POST: begin
        // Everything is inside the limits here, so only the count trim acts.
        if (clean_step) begin
          act      = drop_low ? srtb_pkg::CELL_SHIFT : srtb_pkg::CELL_HOLD;
          cnt_next = cnt_cleaned;
        end else begin
          state_next = srtb_pkg::ST_IDLE;
        end
      end

      srtb_pkg::ST_READ: begin
        if (!res_valid || res.ready) begin
          res_load = 1'b1;
          if (cnt == '0) begin
            res_entry_next = '0;
            res_last_next  = 1'b1;
            res_empty_next = 1'b1;
            state_next     = srtb_pkg::ST_IDLE;
          end else begin
            // After cnt rotations the row is back in its original order.
            act = srtb_pkg::CELL_ROTATE;
            if (rd_last) begin
              rd_idx_next = '0;
              state_next  = srtb_pkg::ST_IDLE;
            end else begin
              rd_idx_next = rd_idx + IDX_W'(1);
            end
          end
        end
      end

      default: begin
        state_next = srtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_hold    <= cmd.op;
      value_hold <= cmd.value;
    end
  end

  // ---------------------------------------------------------------------
  // Result register: holds a beat while the receiver stalls.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_entry <= res_entry_next;
      res_last  <= res_last_next;
      res_empty <= res_empty_next;
    end
  end

  assign res.valid     = res_valid;
  assign res.entry     = res_entry;
  assign res.last      = res_last;
  assign res.empty_res = res_empty;

endmodule

>>> hw/rtl/srtb_checker.sv
// Port-level checks of the sorted range trim buffer, bound to its top level.
// Depends on the assertion macros in sorted_range_trim_buffer_defines.svh.
`include "sorted_range_trim_buffer_defines.svh"

module srtb_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cmd_valid,
  input logic                          cmd_ready,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic signed [VALUE_WIDTH-1:0] res_entry,
  input logic                          res_last,
  input logic                          res_empty_res
);

  // A stalled result beat keeps its contents.
  `SRTB_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready,
    res_valid && $stable(res_entry) && $stable(res_last) && $stable(res_empty_res))

  // The empty beat is the only beat of its read-out and carries a zero entry.
  `SRTB_ASSERT_NOW(a_empty_beat, clk, rst, res_valid && res_empty_res,
    res_last && (res_entry == '0))

  // A taken command is worked on before the next one is taken.
  `SRTB_ASSERT_NEXT(a_one_cmd, clk, rst, cmd_valid && cmd_ready, !cmd_ready)

endmodule

bind sorted_range_trim_buffer srtb_checker #(
  .VALUE_WIDTH(VALUE_WIDTH)
) u_srtb_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .res_entry    (res.entry),
  .res_last     (res.last),
  .res_empty_res(res.empty_res)
);
